@@ rtl/aqfp_pkg.sv @@
// Shared types, character codes and constants for the ASCII four-field frame parser.
// No dependencies; every other file of the block imports this package.
package aqfp_pkg;

    localparam int BYTE_W    = 8;
    localparam int VAL_W     = 21;
    localparam int MAG_W     = 20;
    localparam int CFG_IDX_W = 1;

    localparam int MAX_DIGITS_DEF = 6;
    localparam int WIDTH_CAP      = 999999;

    typedef logic signed [VAL_W-1:0] t_val;
    typedef logic [MAG_W-1:0]        t_mag;
    typedef logic [BYTE_W-1:0]       t_byte;
    typedef logic [CFG_IDX_W-1:0]    t_cfg_idx;

    typedef enum logic [1:0] {
        FLD_PITCH,
        FLD_YAW,
        FLD_PITCH_RATE,
        FLD_YAW_RATE
    } t_field;

    localparam t_cfg_idx REG_PITCH_LO = t_cfg_idx'(0);
    localparam t_cfg_idx REG_PITCH_HI = t_cfg_idx'(1);

    localparam t_val PITCH_LO_RST = t_val'(200);
    localparam t_val PITCH_HI_RST = t_val'(17800);

    localparam t_byte CH_0     = 8'h30;
    localparam t_byte CH_9     = 8'h39;
    localparam t_byte CH_MINUS = 8'h2D;
    localparam t_byte CH_COMMA = 8'h2C;
    localparam t_byte CH_SEMI  = 8'h3B;

    // Largest magnitude a field may hold: all nines over the digit count, capped
    // so that every value fits the signed field width.
    function automatic int digit_bound(input int n);
        int b;
        b = 1;
        for (int i = 0; i < n && b <= WIDTH_CAP; i++) begin
            b = b * 10;
        end
        b = b - 1;
        if (b > WIDTH_CAP) begin
            b = WIDTH_CAP;
        end
        return b;
    endfunction

endpackage

@@ rtl/aqfp_byte_if.sv @@
// Valid/ready channel that carries one received ASCII byte per item.
// Depends on aqfp_pkg.
interface aqfp_byte_if;
    import aqfp_pkg::*;

    logic  valid;
    logic  ready;
    t_byte in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

@@ rtl/aqfp_pose_if.sv @@
// Valid/ready channel that carries one parsed pose frame per item.
// Depends on aqfp_pkg.
interface aqfp_pose_if;
    import aqfp_pkg::*;

    logic valid;
    logic ready;
    t_val pitch_out;
    t_val yaw_out;
    t_val pitch_rate_out;
    t_val yaw_rate_out;
    logic frame_error;

    modport source (output valid, output pitch_out, output yaw_out, output pitch_rate_out,
                    output yaw_rate_out, output frame_error, input ready);
    modport sink   (input valid, input pitch_out, input yaw_out, input pitch_rate_out,
                    input yaw_rate_out, input frame_error, output ready);
endinterface

@@ rtl/ascii_signed_quad_field_parser.sv @@
// Parses ASCII frames of four signed decimal fields into one pose result per frame.
// A ';' item yields its result through the input register, then the result register.
// Throughput: one byte per cycle; the input stage only holds when a ';' meets an
// unread result. Reset (synchronous, active low) clears the field parser, the held
// fields and both valid flags and loads the pitch limits 200 / 17800.
// Depends on aqfp_pkg, aqfp_byte_if and aqfp_pose_if.
module ascii_signed_quad_field_parser #(
    parameter int MAX_DIGITS = aqfp_pkg::MAX_DIGITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  aqfp_pkg::t_cfg_idx            i_cfg_idx,
    input  logic [aqfp_pkg::VAL_W-1:0]    i_cfg_data,
    aqfp_byte_if.sink                     i_byte_ch,
    aqfp_pose_if.source                   o_pose_ch
);
    import aqfp_pkg::*;

    localparam t_mag BOUND = t_mag'(digit_bound(MAX_DIGITS));
    localparam int   PROD_W = MAG_W + 4;

    // Configuration.
    t_val r_pitch_lo, r_pitch_hi;

    // Input stage.
    logic  r_byte_vld, n_byte_vld;
    t_byte r_byte;

    // Field parser state.
    t_field r_field, n_field;
    t_mag   r_accum, n_accum;
    logic   r_minus, n_minus;
    logic   r_at_start, n_at_start;
    logic   r_bad, n_bad;
    t_val   r_held_pitch, n_held_pitch;
    t_val   r_held_yaw, n_held_yaw;
    t_val   r_held_rate, n_held_rate;

    // Result stage.
    logic r_out_vld, n_out_vld;
    t_val r_pitch_out, r_yaw_out, r_rate_out, r_yaw_rate_out;
    logic r_frame_err;

    logic              is_semi, is_digit, is_comma_store, adv, in_acc;
    t_val              mag_val, fld_val;
    logic [PROD_W-1:0] prod;
    t_val              sel_p, sel_y, sel_pr, sel_yr, p_low, p_clamp;

    assign is_semi        = (r_byte == CH_SEMI);
    assign is_digit       = (r_byte >= CH_0) && (r_byte <= CH_9);
    assign is_comma_store = (r_byte == CH_COMMA) && (r_field != FLD_YAW_RATE);

    // A ';' may only move on when the result register is free or being emptied.
    assign adv    = r_byte_vld && (!is_semi || !r_out_vld || o_pose_ch.ready);
    assign in_acc = i_byte_ch.valid && i_byte_ch.ready;
    assign i_byte_ch.ready = !r_byte_vld || adv;

    // A bad character forces magnitude -1 before the sign is applied.
    assign mag_val = r_bad ? t_val'(-1) : t_val'({1'b0, r_accum});
    assign fld_val = r_minus ? -mag_val : mag_val;

    assign prod = ({{4{1'b0}}, r_accum} << 3) + ({{4{1'b0}}, r_accum} << 1)
                + PROD_W'(r_byte[3:0]);

    always_comb begin
        sel_p  = r_held_pitch;
        sel_y  = r_held_yaw;
        sel_pr = r_held_rate;
        sel_yr = '0;
        case (r_field)
            FLD_PITCH: begin
                sel_p  = fld_val;
                sel_y  = '0;
                sel_pr = '0;
            end
            FLD_YAW: begin
                sel_y  = fld_val;
                sel_pr = '0;
            end
            FLD_PITCH_RATE: begin
                sel_pr = fld_val;
            end
            default: begin
                sel_yr = fld_val;
            end
        endcase
        p_low   = (sel_p < r_pitch_lo) ? r_pitch_lo : sel_p;
        p_clamp = (p_low > r_pitch_hi) ? r_pitch_hi : p_low;
    end

    always_comb begin
        n_byte_vld   = r_byte_vld;
        n_field      = r_field;
        n_accum      = r_accum;
        n_minus      = r_minus;
        n_at_start   = r_at_start;
        n_bad        = r_bad;
        n_held_pitch = r_held_pitch;
        n_held_yaw   = r_held_yaw;
        n_held_rate  = r_held_rate;
        n_out_vld    = r_out_vld && !o_pose_ch.ready;

        if (adv) begin
            n_byte_vld = 1'b0;
        end
        if (in_acc) begin
            n_byte_vld = 1'b1;
        end

        if (adv) begin
            if (is_semi) begin
                n_out_vld    = 1'b1;
                n_field      = FLD_PITCH;
                n_accum      = '0;
                n_minus      = 1'b0;
                n_at_start   = 1'b1;
                n_bad        = 1'b0;
                n_held_pitch = '0;
                n_held_yaw   = '0;
                n_held_rate  = '0;
            end else if (is_comma_store) begin
                case (r_field)
                    FLD_PITCH:      n_held_pitch = fld_val;
                    FLD_YAW:        n_held_yaw   = fld_val;
                    default:        n_held_rate  = fld_val;
                endcase
                n_field    = t_field'(r_field + 2'd1);
                n_accum    = '0;
                n_minus    = 1'b0;
                n_at_start = 1'b1;
                n_bad      = 1'b0;
            end else begin
                if (r_byte == CH_MINUS && r_at_start) begin
                    n_minus = 1'b1;
                end else if (is_digit) begin
                    if (!r_bad) begin
                        n_accum = (prod > PROD_W'(BOUND)) ? BOUND : prod[MAG_W-1:0];
                    end
                end else begin
                    n_bad = 1'b1;
                end
                n_at_start = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pitch_lo   <= PITCH_LO_RST;
            r_pitch_hi   <= PITCH_HI_RST;
            r_byte_vld   <= 1'b0;
            r_field      <= FLD_PITCH;
            r_accum      <= '0;
            r_minus      <= 1'b0;
            r_at_start   <= 1'b1;
            r_bad        <= 1'b0;
            r_held_pitch <= '0;
            r_held_yaw   <= '0;
            r_held_rate  <= '0;
            r_out_vld    <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_idx == REG_PITCH_LO) begin
                r_pitch_lo <= t_val'(i_cfg_data);
            end
            if (i_cfg_we && i_cfg_idx == REG_PITCH_HI) begin
                r_pitch_hi <= t_val'(i_cfg_data);
            end
            r_byte_vld   <= n_byte_vld;
            r_field      <= n_field;
            r_accum      <= n_accum;
            r_minus      <= n_minus;
            r_at_start   <= n_at_start;
            r_bad        <= n_bad;
            r_held_pitch <= n_held_pitch;
            r_held_yaw   <= n_held_yaw;
            r_held_rate  <= n_held_rate;
            r_out_vld    <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_byte <= i_byte_ch.in_byte;
        end
        if (adv && is_semi) begin
            r_pitch_out    <= p_clamp;
            r_yaw_out      <= -sel_y;
            r_rate_out     <= sel_pr;
            r_yaw_rate_out <= -sel_yr;
            r_frame_err    <= (r_field != FLD_YAW_RATE);
        end
    end

    assign o_pose_ch.valid          = r_out_vld;
    assign o_pose_ch.pitch_out      = r_pitch_out;
    assign o_pose_ch.yaw_out        = r_yaw_out;
    assign o_pose_ch.pitch_rate_out = r_rate_out;
    assign o_pose_ch.yaw_rate_out   = r_yaw_rate_out;
    assign o_pose_ch.frame_error    = r_frame_err;

    // The field parser restarts at field one after every frame end.
    a_semi_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && is_semi |=> r_field == FLD_PITCH && r_at_start && !r_bad)
        else $error("field parser did not restart after semicolon");

    a_accum_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_accum <= BOUND)
        else $error("magnitude accumulator above digit bound");

    // Once a field has taken a bad character it stays bad until the field ends.
    a_bad_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && !is_semi && !is_comma_store && r_bad |=> r_bad)
        else $error("bad character flag dropped inside a field");

    a_start_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_at_start |-> r_accum == '0 && !r_bad && !r_minus)
        else $error("field start flag set with a non-empty field");

    // A result is not overwritten while unread.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !o_pose_ch.ready |-> !(adv && is_semi))
        else $error("result register overwritten before it was taken");

endmodule
